// ===== rtl/mzg_pkg.sv =====
// ----------------------------------------------------------------------------
// mzg_pkg: maze generator shared types and constants
// Cell codes, register indexes, command codes and the LCG constants.
// ----------------------------------------------------------------------------
`default_nettype none
package mzg_pkg;
  localparam int GridSideDef   = 64;
  localparam int StackDepthDef = 1024;
  localparam logic [31:0] LcgMul = 32'd1103515245;
  localparam logic [31:0] LcgInc = 32'd12345;
  localparam int LoopFactor = 10;

  typedef enum logic [1:0] {
    CODE_WALL  = 2'd0,
    CODE_PATH  = 2'd1,
    CODE_START = 2'd2,
    CODE_GOAL  = 2'd3
  } cell_code_e;

  localparam logic [1:0] RegSeed   = 2'd0;
  localparam logic [1:0] RegWidth  = 2'd1;
  localparam logic [1:0] RegHeight = 2'd2;
  localparam logic [1:0] RegExtra  = 2'd3;

  localparam logic OpGenerate = 1'b0;
  localparam logic OpRead     = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
  } cmd_t;

  typedef struct packed {
    logic [1:0] cell_code;
    logic [5:0] maze_width;
    logic [5:0] maze_height;
    logic [7:0] loops_added;
  } rsp_t;

  // round a request up to odd and clamp into the grid
  function automatic logic [5:0] odd_dim(input logic [5:0] req, input logic [5:0] cap);
    logic [6:0] d;
    d = (req < 6'd3) ? 7'd3 : {1'b0, req};
    if (!d[0]) d = d + 7'd1;
    if (d > {1'b0, cap}) d = {1'b0, cap};
    return d[5:0];
  endfunction
endpackage
`default_nettype wire

// ===== rtl/mzg_if.sv =====
// ----------------------------------------------------------------------------
// mzg_cmd_if / mzg_rsp_if: valid-ready channels
// Command and response channels with source and sink modports.
// ----------------------------------------------------------------------------
`default_nettype none
interface mzg_cmd_if import mzg_pkg::*; ;
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mzg_rsp_if import mzg_pkg::*; ;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/maze_generator_dfs_with_loops.sv =====
// A cell read presents the grid address on acceptance and registers its response in
// S_RD; no new command is accepted while a response is pending. A generate takes a
// clearing sweep of the grid, then three LCG draws per carved node in the shared
// range-reduction unit, plus the loop pass of up to 10 times the extra register
// value attempts of at most two such draws each. One item is in work at a time.
// Reset clears control state; the grid is then swept to wall.
// ----------------------------------------------------------------------------
// maze_generator_dfs_with_loops: randomized DFS maze generator
// Sequencer over one grid memory, one stack memory and the shared LCG unit.
// ----------------------------------------------------------------------------
`default_nettype none
module maze_generator_dfs_with_loops import mzg_pkg::*; #(
  parameter int GRID_SIDE   = GridSideDef,
  parameter int STACK_DEPTH = StackDepthDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_idx_i,
  input  wire logic [31:0]  cfg_data_i,
  mzg_cmd_if.sink           cmd,
  mzg_rsp_if.source         rsp
);
  localparam int CW = $clog2(GRID_SIDE);
  localparam int AW = 2 * CW;
  localparam int SW = $clog2(STACK_DEPTH);
  localparam int CapI = (GRID_SIDE - 1) % 2 == 1 ? GRID_SIDE - 1 : GRID_SIDE - 2;
  localparam logic [5:0] Cap = (CapI > 63) ? 6'd63 : CapI[5:0];

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_RD, S_RDW, S_OUT, S_GCLR, S_ENTER, S_SHUF, S_SHUFW, S_PUSH,
    S_TOP, S_TOPW, S_NB, S_NBW, S_CARVE, S_MARK, S_LPX, S_LPXW, S_LPY, S_LPYW,
    S_LC, S_LCW, S_LN, S_LNW, S_LEND
  } st_e;

  // grid memory: {visited, code}
  logic [2:0] grid_mem [GRID_SIDE*GRID_SIDE];
  logic [22:0] stk_mem [STACK_DEPTH];
  logic        g_we;
  logic [AW-1:0] g_wa, g_ra;
  logic [2:0]  g_wd, g_rd_q;
  logic        s_we;
  logic [SW-1:0] s_wa, s_ra;
  logic [22:0] s_wd, s_rd_q;

  always_ff @(posedge clk_i) begin
    if (g_we) grid_mem[g_wa] <= g_wd;
    g_rd_q <= grid_mem[g_ra];
    if (s_we) stk_mem[s_wa] <= s_wd;
    s_rd_q <= stk_mem[s_ra];
  end

  st_e st_q;
  logic [AW:0]  clr_q;
  logic [5:0]   wreq_q, hreq_q, w_q, h_q;
  logic [7:0]   extra_q, added_q;
  logic [SW:0]  sp_q;
  logic [5:0]   fx_q, fy_q;
  logic [2:0]   fnext_q;
  logic [7:0]   ford_q;
  logic [1:0]   si_q;
  logic [2:0]   nopen_q;
  logic [11:0]  tries_q;
  logic [5:0]   lx_q, ly_q;
  logic [1:0]   code_q;
  logic         rsp_v_q;
  rsp_t         rsp_q;

  logic       lcg_start;
  logic [6:0] lcg_span, lcg_rem;
  logic       lcg_done;

  mzg_lcg u_lcg (
    .clk_i, .rst_ni,
    .seed_we_i (cfg_we_i && cfg_idx_i == RegSeed),
    .seed_i    (cfg_data_i),
    .start_i   (lcg_start),
    .span_i    (lcg_span),
    .done_o    (lcg_done),
    .rem_o     (lcg_rem)
  );

  function automatic logic [AW-1:0] adr(input logic [5:0] x, input logic [5:0] y);
    logic [CW-1:0] xx, yy;
    xx = CW'(x);
    yy = CW'(y);
    return {yy, xx};
  endfunction

  // direction currently tried and neighbor
  logic [1:0] dir;
  logic signed [7:0] nx, ny;
  logic [5:0] wx, wy;
  logic nb_ok;
  logic [22:0] top_fr;
  assign top_fr = s_rd_q;
  always_comb begin
    case (fnext_q[1:0])
      2'd0: dir = ford_q[1:0];
      2'd1: dir = ford_q[3:2];
      2'd2: dir = ford_q[5:4];
      default: dir = ford_q[7:6];
    endcase
    nx = $signed({2'b00, fx_q}); ny = $signed({2'b00, fy_q});
    case (dir)
      2'd0: ny = ny - 8'sd2;
      2'd1: nx = nx + 8'sd2;
      2'd2: ny = ny + 8'sd2;
      default: nx = nx - 8'sd2;
    endcase
    wx = (dir == 2'd1) ? fx_q + 6'd1 : (dir == 2'd3) ? fx_q - 6'd1 : fx_q;
    wy = (dir == 2'd2) ? fy_q + 6'd1 : (dir == 2'd0) ? fy_q - 6'd1 : fy_q;
    nb_ok = (nx > 0) && (nx < $signed({2'b00, w_q})) && (ny > 0) &&
            (ny < $signed({2'b00, h_q}));
  end

  logic [11:0] limit;
  assign limit = (extra_q == 8'd0) ? 12'd1 : 12'(extra_q) * 12'(LoopFactor);

  // another loop attempt is due
  logic lp_go;
  assign lp_go = (added_q < extra_q) && (tries_q < limit);

  logic [7:0] ord_sw;
  always_comb begin
    logic [1:0] a, b;
    ord_sw = ford_q;
    a = ford_q[2*si_q +: 2];
    b = ford_q[2*lcg_rem[1:0] +: 2];
    ord_sw[2*si_q +: 2] = b;
    ord_sw[2*lcg_rem[1:0] +: 2] = a;
  end

  always_comb begin
    g_we = 1'b0; g_wa = '0; g_wd = '0; g_ra = '0;
    s_we = 1'b0; s_wa = sp_q[SW-1:0]; s_wd = {fx_q, fy_q, fnext_q, ford_q};
    s_ra = '0; lcg_start = 1'b0; lcg_span = 7'd1;
    case (st_q)
      S_CLR, S_GCLR: begin g_we = 1'b1; g_wa = clr_q[AW-1:0]; g_wd = 3'b000; end
      S_IDLE: g_ra = adr(cmd.data.cell_x, cmd.data.cell_y);
      S_ENTER: begin g_we = 1'b1; g_wa = adr(fx_q, fy_q); g_wd = {1'b1, CODE_PATH}; end
      S_SHUF: begin lcg_start = 1'b1; lcg_span = 7'(si_q) + 7'd1; end
      S_PUSH: s_we = 1'b1;
      S_TOP: s_ra = SW'(sp_q - 1'b1);
      S_NB: begin
        s_we = 1'b1; s_wa = SW'(sp_q - 1'b1);
        s_wd = {fx_q, fy_q, fnext_q + 3'd1, ford_q};
        g_ra = adr(nx[5:0], ny[5:0]);
      end
      S_CARVE: begin g_we = 1'b1; g_wa = adr(wx, wy); g_wd = {1'b0, CODE_PATH}; end
      S_MARK: begin
        g_we = 1'b1;
        g_wa = (clr_q[0]) ? adr(6'd1, 6'd1) : adr(w_q - 6'd2, h_q - 6'd2);
        g_wd = clr_q[0] ? {1'b1, CODE_START} : {1'b1, CODE_GOAL};
      end
      // a one-wide range takes no draw
      S_LPX: if (lp_go && w_q != 6'd3) begin
        lcg_start = 1'b1; lcg_span = 7'(w_q - 6'd2);
      end
      S_LPY: if (h_q != 6'd3) begin
        lcg_start = 1'b1; lcg_span = 7'(h_q - 6'd2);
      end
      S_LC: g_ra = adr(lx_q, ly_q);
      S_LN: begin
        case (si_q)
          2'd0: g_ra = adr(lx_q, ly_q - 6'd1);
          2'd1: g_ra = adr(lx_q + 6'd1, ly_q);
          2'd2: g_ra = adr(lx_q, ly_q + 6'd1);
          default: g_ra = adr(lx_q - 6'd1, ly_q);
        endcase
      end
      S_LEND: if (nopen_q >= 3'd2) begin
        g_we = 1'b1; g_wa = adr(lx_q, ly_q); g_wd = {1'b1, CODE_PATH};
      end
      default: ;
    endcase
  end

  assign cmd.ready = (st_q == S_IDLE) && !rsp_v_q;
  assign rsp.valid = rsp_v_q;
  assign rsp.data  = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR; clr_q <= '0; wreq_q <= 6'd15; hreq_q <= 6'd15; extra_q <= '0;
      w_q <= 6'd15; h_q <= 6'd15; added_q <= '0; sp_q <= '0; rsp_v_q <= 1'b0;
      fx_q <= '0; fy_q <= '0; fnext_q <= '0; ford_q <= '0; si_q <= '0;
      nopen_q <= '0; tries_q <= '0; lx_q <= '0; ly_q <= '0; code_q <= '0;
      rsp_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegWidth:  wreq_q <= cfg_data_i[5:0];
          RegHeight: hreq_q <= cfg_data_i[5:0];
          RegExtra:  extra_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (rsp_v_q && rsp.ready) rsp_v_q <= 1'b0;
      case (st_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q[AW-1:0] == '1) st_q <= S_IDLE;
        end
        S_IDLE: if (cmd.valid && cmd.ready) begin
          if (cmd.data.opcode == OpRead) begin
            code_q <= (cmd.data.cell_x < w_q && cmd.data.cell_y < h_q) ? 2'd1 : 2'd0;
            st_q <= S_RD;
          end else begin
            w_q <= odd_dim(wreq_q, Cap); h_q <= odd_dim(hreq_q, Cap);
            clr_q <= '0; st_q <= S_GCLR;
          end
        end
        S_RD: begin
          rsp_q <= '{cell_code: code_q[0] ? g_rd_q[1:0] : CODE_WALL,
                     maze_width: w_q, maze_height: h_q, loops_added: added_q};
          rsp_v_q <= 1'b1; st_q <= S_IDLE;
        end
        S_GCLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q[AW-1:0] == '1) begin
            sp_q <= '0; fx_q <= 6'd1; fy_q <= 6'd1; st_q <= S_ENTER;
          end
        end
        S_ENTER: begin
          fnext_q <= '0; ford_q <= 8'b11_10_01_00; si_q <= 2'd3; st_q <= S_SHUF;
        end
        S_SHUF: st_q <= S_SHUFW;
        S_SHUFW: if (lcg_done) begin
          ford_q <= ord_sw;
          if (si_q == 2'd1) st_q <= S_PUSH;
          else begin si_q <= si_q - 2'd1; st_q <= S_SHUF; end
        end
        S_PUSH: begin sp_q <= sp_q + 1'b1; st_q <= S_TOP; end
        S_TOP: begin
          if (sp_q == '0) begin clr_q <= (AW+1)'(1); st_q <= S_MARK; end
          else st_q <= S_TOPW;
        end
        S_TOPW: begin
          {fx_q, fy_q, fnext_q, ford_q} <= top_fr;
          if (top_fr[10:8] >= 3'd4) begin sp_q <= sp_q - 1'b1; st_q <= S_TOP; end
          else st_q <= S_NB;
        end
        S_NB: st_q <= S_NBW;
        S_NBW: begin
          if (nb_ok && !g_rd_q[2] && sp_q < (SW+1)'(STACK_DEPTH)) st_q <= S_CARVE;
          else st_q <= S_TOP;
        end
        S_CARVE: begin fx_q <= nx[5:0]; fy_q <= ny[5:0]; st_q <= S_ENTER; end
        S_MARK: begin
          if (clr_q[0]) clr_q[0] <= 1'b0;
          else begin added_q <= '0; tries_q <= '0; st_q <= S_LPX; end
        end
        S_LPX: begin
          if (!lp_go) begin
            rsp_q <= '{cell_code: CODE_WALL, maze_width: w_q, maze_height: h_q,
                       loops_added: added_q};
            rsp_v_q <= 1'b1; st_q <= S_IDLE;
          end else if (w_q == 6'd3) begin lx_q <= 6'd1; st_q <= S_LPY; end
          else st_q <= S_LPXW;
        end
        S_LPXW: if (lcg_done) begin lx_q <= 6'd1 + lcg_rem[5:0]; st_q <= S_LPY; end
        S_LPY: begin
          if (h_q == 6'd3) begin ly_q <= 6'd1; st_q <= S_LC; end
          else st_q <= S_LPYW;
        end
        S_LPYW: if (lcg_done) begin ly_q <= 6'd1 + lcg_rem[5:0]; st_q <= S_LC; end
        S_LC: st_q <= S_LCW;
        S_LCW: begin
          nopen_q <= '0; si_q <= '0;
          if (g_rd_q[1:0] == CODE_WALL) st_q <= S_LN;
          else begin tries_q <= tries_q + 1'b1; st_q <= S_LPX; end
        end
        S_LN: st_q <= S_LNW;
        S_LNW: begin
          if (g_rd_q[1:0] != CODE_WALL) nopen_q <= nopen_q + 3'd1;
          if (si_q == 2'd3) st_q <= S_LEND;
          else begin si_q <= si_q + 2'd1; st_q <= S_LN; end
        end
        S_LEND: begin
          if (nopen_q >= 3'd2) added_q <= added_q + 8'd1;
          tries_q <= tries_q + 1'b1; st_q <= S_LPX;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ready |-> st_q == S_IDLE) else $error("ready outside idle");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_v_q |-> !cmd.ready) else $error("accept while result pending");
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= (SW+1)'(STACK_DEPTH)) else $error("stack overflow");
endmodule
`default_nettype wire

// ===== rtl/mzg_lcg.sv =====
// ----------------------------------------------------------------------------
// mzg_lcg: random draw unit
// Holds the LCG state; a draw advances it and reduces the result modulo the span
// by repeated subtraction of the shifted span.
// ----------------------------------------------------------------------------
`default_nettype none
module mzg_lcg import mzg_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        seed_we_i,
  input  wire logic [31:0] seed_i,
  input  wire logic        start_i,
  input  wire logic [6:0]  span_i,
  output logic             done_o,
  output logic [6:0]       rem_o
);
  typedef enum logic [1:0] {S_IDLE, S_MUL, S_RED} st_e;
  st_e st_q;
  logic [31:0] rng_q;
  logic [30:0] rem_q;
  logic [6:0]  span_q;
  logic [4:0]  sh_q;
  logic [37:0] dv;
  logic [31:0] prod;

  assign prod = rng_q * LcgMul + LcgInc;
  assign dv   = {31'd0, span_q} << sh_q;
  assign done_o = (st_q == S_RED) && (sh_q == 5'd0) && ({7'd0, rem_q} < dv);
  assign rem_o  = rem_q[6:0];

  // restoring reduction: subtract the shifted span while it fits, then shift down
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; rng_q <= '0; rem_q <= '0; span_q <= 7'd1; sh_q <= '0;
    end else if (seed_we_i) begin
      rng_q <= seed_i;
    end else begin
      case (st_q)
        S_IDLE: if (start_i) begin span_q <= span_i; st_q <= S_MUL; end
        S_MUL: begin
          rng_q <= {1'b0, prod[30:0]};
          rem_q <= prod[30:0];
          sh_q  <= 5'd24;
          st_q  <= S_RED;
        end
        S_RED: begin
          if ({7'd0, rem_q} >= dv) rem_q <= rem_q - dv[30:0];
          else if (sh_q != 5'd0) sh_q <= sh_q - 5'd1;
          else st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== tb/tb_maze_generator_dfs_with_loops.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_maze_generator_dfs_with_loops: self-checking bench for the maze generator
// Programs seed, size and loop count, issues generate commands and cell reads,
// and checks each response against a behavioral model of the DFS carve and
// loop pass kept inside the bench, with random stalls on both channels in most phases.
// ----------------------------------------------------------------------------
module tb_maze_generator_dfs_with_loops;
  import mzg_pkg::*;

  localparam int Side  = GridSideDef;
  localparam int Depth = StackDepthDef;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;

  mzg_cmd_if cmd_ch ();
  mzg_rsp_if rsp_ch ();

  maze_generator_dfs_with_loops dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd        (cmd_ch.sink),
    .rsp        (rsp_ch.source)
  );

  // model state
  cell_code_e  maze_grid [Side*Side];
  bit          visited [Side*Side];
  int          dfs_x [Depth];
  int          dfs_y [Depth];
  int          dfs_next [Depth];
  int          dfs_dir [Depth][4];
  int          dfs_top;
  logic [31:0] rng_q;
  logic [5:0]  req_w, req_h;
  logic [7:0]  loops_req;
  logic [5:0]  cur_w, cur_h;
  logic [7:0]  loops_done;

  cmd_t pending_cmds[$];
  rsp_t expected_rsps[$];
  int   send_idle, recv_idle;
  int   mismatch_cnt;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [5:0] fold_odd(logic [5:0] req);
    int d, cap;
    cap = (Side % 2 == 0) ? Side - 1 : Side - 2;
    d = (req < 3) ? 3 : int'(req);
    if (d % 2 == 0) d++;
    if (d > cap) d = cap;
    return d[5:0];
  endfunction

  function automatic int lcg_pick(int lo, int hi);
    if (lo >= hi) return lo;
    rng_q = (rng_q * LcgMul + LcgInc) & 32'h7fff_ffff;
    return lo + int'(rng_q % (hi - lo + 1));
  endfunction

  function automatic void push_node(int x, int y);
    int j, t;
    visited[y*Side + x] = 1'b1;
    dfs_x[dfs_top] = x;
    dfs_y[dfs_top] = y;
    dfs_next[dfs_top] = 0;
    for (int i = 0; i < 4; i++) dfs_dir[dfs_top][i] = i;
    for (int i = 3; i > 0; i--) begin
      j = lcg_pick(0, i) & 3;
      t = dfs_dir[dfs_top][i];
      dfs_dir[dfs_top][i] = dfs_dir[dfs_top][j];
      dfs_dir[dfs_top][j] = t;
    end
    dfs_top++;
  endfunction

  function automatic void build_maze();
    int w, h, f, d, nx, ny, sx, sy, x, y, open, added, tries, lim;
    cur_w = fold_odd(req_w);
    cur_h = fold_odd(req_h);
    w = cur_w;
    h = cur_h;
    foreach (maze_grid[i]) begin
      maze_grid[i] = CODE_WALL;
      visited[i] = 1'b0;
    end
    dfs_top = 0;
    maze_grid[Side + 1] = CODE_PATH;
    push_node(1, 1);
    while (dfs_top > 0) begin
      f = dfs_top - 1;
      if (dfs_next[f] >= 4) begin
        dfs_top--;
        continue;
      end
      d = dfs_dir[f][dfs_next[f]];
      dfs_next[f]++;
      // direction order: up, right, down, left
      sx = (d == 1) ? 1 : (d == 3) ? -1 : 0;
      sy = (d == 0) ? -1 : (d == 2) ? 1 : 0;
      nx = dfs_x[f] + 2*sx;
      ny = dfs_y[f] + 2*sy;
      if (nx > 0 && nx < w && ny > 0 && ny < h && !visited[ny*Side + nx] &&
          dfs_top < Depth) begin
        maze_grid[(dfs_y[f] + sy)*Side + dfs_x[f] + sx] = CODE_PATH;
        maze_grid[ny*Side + nx] = CODE_PATH;
        push_node(nx, ny);
      end
    end
    maze_grid[Side + 1] = CODE_START;
    maze_grid[(h-2)*Side + w - 2] = CODE_GOAL;
    added = 0;
    tries = 0;
    lim = (loops_req == 0) ? 1 : LoopFactor * int'(loops_req);
    while (added < loops_req && tries < lim) begin
      x = lcg_pick(1, w - 2);
      y = lcg_pick(1, h - 2);
      if (maze_grid[y*Side + x] == CODE_WALL) begin
        open = 0;
        if (maze_grid[(y-1)*Side + x] != CODE_WALL) open++;
        if (maze_grid[y*Side + x + 1] != CODE_WALL) open++;
        if (maze_grid[(y+1)*Side + x] != CODE_WALL) open++;
        if (maze_grid[y*Side + x - 1] != CODE_WALL) open++;
        if (open >= 2) begin
          maze_grid[y*Side + x] = CODE_PATH;
          added++;
        end
      end
      tries++;
    end
    loops_done = added[7:0];
  endfunction

  function automatic rsp_t predict_rsp(cmd_t c);
    rsp_t r;
    r.cell_code = CODE_WALL;
    if (c.opcode == OpGenerate) build_maze();
    else if (c.cell_x < cur_w && c.cell_y < cur_h)
      r.cell_code = maze_grid[int'(c.cell_y)*Side + int'(c.cell_x)];
    r.maze_width = cur_w;
    r.maze_height = cur_h;
    r.loops_added = loops_done;
    return r;
  endfunction

  // command driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_ch.valid <= 1'b0;
      cmd_ch.data <= '0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) expected_rsps.push_back(predict_rsp(cmd_ch.data));
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle) begin
          cmd_ch.data <= pending_cmds.pop_front();
          cmd_ch.valid <= 1'b1;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsps.size() == 0) begin
          $error("unexpected response item %p", rsp_ch.data);
          mismatch_cnt++;
        end else begin
          rsp_t e;
          e = expected_rsps.pop_front();
          if (e.cell_code !== rsp_ch.data.cell_code) begin
            $error("cell_code exp %0d got %0d", e.cell_code, rsp_ch.data.cell_code);
            mismatch_cnt++;
          end
          if (e.maze_width !== rsp_ch.data.maze_width) begin
            $error("maze_width exp %0d got %0d", e.maze_width, rsp_ch.data.maze_width);
            mismatch_cnt++;
          end
          if (e.maze_height !== rsp_ch.data.maze_height) begin
            $error("maze_height exp %0d got %0d", e.maze_height, rsp_ch.data.maze_height);
            mismatch_cnt++;
          end
          if (e.loops_added !== rsp_ch.data.loops_added) begin
            $error("loops_added exp %0d got %0d", e.loops_added, rsp_ch.data.loops_added);
            mismatch_cnt++;
          end
        end
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || cmd_ch.valid || expected_rsps.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      RegSeed:   rng_q = val;
      RegWidth:  req_w = val[5:0];
      RegHeight: req_h = val[5:0];
      default:   loops_req = val[7:0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_cmd(logic op, int x, int y);
    cmd_t c;
    c.opcode = op;
    c.cell_x = x[5:0];
    c.cell_y = y[5:0];
    pending_cmds.push_back(c);
  endtask

  task automatic set_maze(logic [31:0] s, int w, int h, int lp);
    write_reg(RegSeed, s);
    write_reg(RegWidth, w);
    write_reg(RegHeight, h);
    write_reg(RegExtra, lp);
  endtask

  // reads that mostly land inside the maze of the current size
  task automatic push_reads(int n);
    int mw, mh;
    mw = fold_odd(req_w);
    mh = fold_odd(req_h);
    repeat (n) begin
      if ($urandom_range(9) < 8) push_cmd(OpRead, $urandom_range(mw-1), $urandom_range(mh-1));
      else push_cmd(OpRead, $urandom_range(63), $urandom_range(63));
    end
  endtask

  initial begin
    int nphase, w, h, lp;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    mismatch_cnt = 0;
    send_idle = 23;
    recv_idle = 62;
    rng_q = '0;
    req_w = 6'd15;
    req_h = 6'd15;
    loops_req = '0;
    cur_w = 6'd15;
    cur_h = 6'd15;
    loops_done = '0;
    foreach (maze_grid[i]) begin
      maze_grid[i] = CODE_WALL;
      visited[i] = 1'b0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // before any generate the grid reads as all wall
    push_cmd(OpRead, 1, 1);
    push_cmd(OpRead, 63, 63);
    wait_drained();
    // tiny maze: goal overwrites start
    set_maze(32'hffff_ffff, 0, 2, 255);
    push_cmd(OpGenerate, 0, 0);
    push_cmd(OpRead, 1, 1);
    push_cmd(OpRead, 0, 0);
    push_cmd(OpRead, 2, 2);
    push_cmd(OpRead, 3, 1);
    wait_drained();
    // largest size, with an even request in the other axis rounded up to odd
    set_maze(32'h0, 63, 62, 0);
    push_cmd(OpGenerate, 63, 63);
    push_cmd(OpRead, 61, 61);
    push_cmd(OpRead, 62, 62);
    push_cmd(OpRead, 1, 1);
    push_cmd(OpRead, 0, 63);
    push_cmd(OpRead, 63, 0);
    push_cmd(OpRead, 42, 21);
    wait_drained();
    set_maze(32'h8000_0001, 9, 5, 3);
    push_cmd(OpGenerate, 0, 0);
    push_cmd(OpRead, 7, 3);
    push_cmd(OpRead, 9, 3);
    push_cmd(OpRead, 4, 5);
    wait_drained();

    nphase = 40;
    for (int p = 0; p < nphase; p++) begin
      if (p < nphase/3) begin
        send_idle = 23;
        recv_idle = 62;
      end else if (p < 2*nphase/3) begin
        send_idle = 62;
        recv_idle = 23;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (p % 10 == 9) begin
        w = $urandom_range(50, 63);
        h = $urandom_range(50, 63);
        lp = $urandom_range(0, 12);
      end else begin
        w = (p % 5 == 0) ? $urandom_range(0, 63) : $urandom_range(0, 21);
        h = (p % 5 == 1) ? $urandom_range(0, 63) : $urandom_range(0, 21);
        lp = (p % 4 == 0) ? $urandom_range(0, 255) : $urandom_range(0, 15);
      end
      set_maze($urandom, w, h, lp);
      push_cmd(OpGenerate, $urandom_range(63), $urandom_range(63));
      push_reads(15);
      // hold the sender until the maze above is fully read back
      if (p % 3 == 0) wait_drained();
      // a second generate continues the random sequence from its current state
      if (p % 2 == 1) push_cmd(OpGenerate, 0, 0);
      push_reads(15);
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0) $display("tb_maze_generator_dfs_with_loops OK");
    else $display("tb_maze_generator_dfs_with_loops NOT OK");
    $finish;
  end

  initial begin
    repeat (40) #100_000_000;
    $display("tb_maze_generator_dfs_with_loops NOT OK");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/mzg_pkg.sv
rtl/mzg_if.sv
rtl/mzg_lcg.sv
rtl/maze_generator_dfs_with_loops.sv
tb/tb_maze_generator_dfs_with_loops.sv
